### sv/multi_level_priority_fifo_assert.svh
// Assertion macros for the priority queue back end (mlpq_back).
// The clocked form is quiet while rst_n is low; the reset form also checks across reset.
`ifndef MULTI_LEVEL_PRIORITY_FIFO_ASSERT_SVH
`define MULTI_LEVEL_PRIORITY_FIFO_ASSERT_SVH
`ifndef SYNTHESIS
`define MLPQ_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MLPQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MLPQ_ASSERT_CLK(lbl, prop, msg)
`define MLPQ_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### sv/mlpq_pkg.sv
package mlpq_pkg;

  localparam int DATA_W  = 32;
  localparam int LEVEL_W = 3;
  localparam int STAT_W  = 3;

  typedef enum logic [STAT_W-1:0] {
    ST_ENQ    = 3'd0,
    ST_DEQ    = 3'd1,
    ST_BADPRI = 3'd2,
    ST_FULL   = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    K_ENQ    = 2'd0,
    K_DEQ    = 2'd1,
    K_BADPRI = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [DATA_W-1:0]   value;
    logic [LEVEL_W-1:0]  level;
  } cmd_t;

endpackage

### sv/mlpq_ram.sv
module mlpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/mlpq_front.sv
module mlpq_front import mlpq_pkg::*; #(
  parameter int LEVELS = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic [DATA_W-1:0]  in_value,
  input  logic [LEVEL_W-1:0] in_priority_req,
  output logic               cmd_valid,
  output cmd_t               cmd,
  input  logic               cmd_pop
);

  localparam logic [LEVEL_W:0] LEVELS_W = (LEVEL_W+1)'(LEVELS);

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  cmd_t       cls;
  logic       push;
  logic       pop;

  // classify the beat before it enters the queue
  always_comb begin
    cls.value = in_value;
    cls.level = in_priority_req;
    if (in_action) begin
      cls.kind = K_DEQ;
    end else if ({1'b0, in_priority_req} >= LEVELS_W) begin
      cls.kind = K_BADPRI;
    end else begin
      cls.kind = K_ENQ;
    end
  end

  assign busy      = (count_r == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (count_r != 2'd0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### sv/mlpq_back.sv
`include "multi_level_priority_fifo_assert.svh"

module mlpq_back import mlpq_pkg::*; #(
  parameter int LEVELS = 3,
  parameter int DEPTH  = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  output logic               out_strobe,
  output logic [STAT_W-1:0]  out_status,
  output logic [DATA_W-1:0]  out_data_out,
  output logic [LEVEL_W-1:0] out_level_out
);

  localparam int AW    = $clog2(DEPTH);
  localparam int LVW   = $clog2(LEVELS);
  localparam int SLOTS = LEVELS * DEPTH;
  localparam int RAW   = $clog2(SLOTS);

  typedef enum logic {S_IDLE, S_DEQ_WAIT} state_t;

  state_t             state_r;
  logic [AW-1:0]      head_r [LEVELS];
  logic [AW-1:0]      tail_r [LEVELS];
  logic [LEVELS-1:0]  empty_r;
  logic [LVW-1:0]     lvl_r;
  logic               out_strobe_r;
  status_t            out_status_r;
  logic [DATA_W-1:0]  out_data_r;
  logic [LEVEL_W-1:0] out_level_r;

  logic [LVW-1:0]     deq_lvl;
  logic               any_full_lvl;
  logic [LVW-1:0]     sel_lvl;
  logic [AW-1:0]      sel_head;
  logic [AW-1:0]      sel_tail;
  logic               sel_empty;
  logic [AW-1:0]      head_inc;
  logic [AW-1:0]      tail_inc;
  logic [AW-1:0]      enq_idx;
  logic               lvl_full;
  logic [RAW-1:0]     base;
  logic               do_enq;
  logic               do_deq;
  logic [DATA_W-1:0]  rdata;

  // lowest-numbered non-empty level wins
  always_comb begin
    deq_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (!empty_r[i]) begin
        deq_lvl = LVW'(i);
      end
    end
  end

  assign any_full_lvl = !(&empty_r);
  assign sel_lvl      = (cmd.kind == K_DEQ) ? deq_lvl : cmd.level[LVW-1:0];
  assign sel_head     = head_r[sel_lvl];
  assign sel_tail     = tail_r[sel_lvl];
  assign sel_empty    = empty_r[sel_lvl];
  assign head_inc     = (sel_head == AW'(DEPTH - 1)) ? '0 : sel_head + 1'b1;
  assign tail_inc     = (sel_tail == AW'(DEPTH - 1)) ? '0 : sel_tail + 1'b1;
  assign lvl_full     = !sel_empty && (sel_head == tail_inc);
  assign enq_idx      = sel_empty ? '0 : tail_inc;
  assign base         = RAW'(sel_lvl) * RAW'(DEPTH);

  assign cmd_pop = (state_r == S_IDLE) && cmd_valid;
  assign do_enq  = cmd_pop && (cmd.kind == K_ENQ) && !lvl_full;
  assign do_deq  = cmd_pop && (cmd.kind == K_DEQ) && any_full_lvl;

  mlpq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (do_enq),
    .waddr (base + RAW'(enq_idx)),
    .wdata (cmd.value),
    .re    (do_deq),
    .raddr (base + RAW'(sel_head)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
      empty_r <= '1;
    end else if (do_enq) begin
      if (sel_empty) begin
        head_r[sel_lvl]  <= '0;
        tail_r[sel_lvl]  <= '0;
        empty_r[sel_lvl] <= 1'b0;
      end else begin
        tail_r[sel_lvl] <= tail_inc;
      end
    end else if (do_deq) begin
      // last entry out: return the level to its empty layout
      if (sel_head == sel_tail) begin
        head_r[sel_lvl]  <= '0;
        tail_r[sel_lvl]  <= '0;
        empty_r[sel_lvl] <= 1'b1;
      end else begin
        head_r[sel_lvl] <= head_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.kind)
              K_ENQ: begin
                out_strobe_r <= 1'b1;
                if (lvl_full) begin
                  out_status_r <= ST_FULL;
                  out_data_r   <= '0;
                  out_level_r  <= '0;
                end else begin
                  out_status_r <= ST_ENQ;
                  out_data_r   <= cmd.value;
                  out_level_r  <= cmd.level;
                end
              end
              K_DEQ: begin
                if (any_full_lvl) begin
                  lvl_r   <= sel_lvl;
                  state_r <= S_DEQ_WAIT;
                end else begin
                  out_strobe_r <= 1'b1;
                  out_status_r <= ST_EMPTY;
                  out_data_r   <= '0;
                  out_level_r  <= '0;
                end
              end
              K_BADPRI: begin
                out_strobe_r <= 1'b1;
                out_status_r <= ST_BADPRI;
                out_data_r   <= '0;
                out_level_r  <= '0;
              end
              default: begin
                out_strobe_r <= 1'b1;
                out_status_r <= ST_BADPRI;
                out_data_r   <= '0;
                out_level_r  <= '0;
              end
            endcase
          end
        end
        S_DEQ_WAIT: begin
          // slot word arrives from the registered read port
          out_strobe_r <= 1'b1;
          out_status_r <= ST_DEQ;
          out_data_r   <= rdata;
          out_level_r  <= LEVEL_W'(lvl_r);
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_status    = out_status_r;
  assign out_data_out  = out_data_r;
  assign out_level_out = out_level_r;

  `MLPQ_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_strobe_r && state_r == S_IDLE, "strobe after reset")
  `MLPQ_ASSERT_CLK(a_deq_resp, state_r == S_DEQ_WAIT |=> out_strobe_r && out_status_r == ST_DEQ, "dequeue lost")
  `MLPQ_ASSERT_CLK(a_empty_ptr, empty_r[0] |-> head_r[0] == '0 && tail_r[0] == '0, "empty level pointers")
  `MLPQ_ASSERT_CLK(a_no_pop_wait, state_r == S_DEQ_WAIT |-> !cmd_pop, "pop during dequeue read")

endmodule

### sv/multi_level_priority_fifo.sv
// Enqueue and error results: command queue entry, result registers, when the back end is free.
// Dequeue results also pass the slot RAM's registered read port, in state S_DEQ_WAIT.
// Sustained rate: one enqueue or error per cycle; a dequeue stalls the next command in S_DEQ_WAIT.
// busy rises when the two-entry command queue is full; results cannot be stalled.
// Synchronous reset empties every level and the command queue; slot contents are not cleared.
module multi_level_priority_fifo import mlpq_pkg::*; #(
  parameter int LEVELS = 3,
  parameter int DEPTH  = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_action,
  input  logic signed [DATA_W-1:0]   in_value,
  input  logic [LEVEL_W-1:0]         in_priority_req,
  output logic                       out_strobe,
  output logic [STAT_W-1:0]          out_status,
  output logic signed [DATA_W-1:0]   out_data_out,
  output logic [LEVEL_W-1:0]         out_level_out
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  mlpq_front #(
    .LEVELS (LEVELS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_value        (in_value),
    .in_priority_req (in_priority_req),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop)
  );

  mlpq_back #(
    .LEVELS (LEVELS),
    .DEPTH  (DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .out_strobe    (out_strobe),
    .out_status    (out_status),
    .out_data_out  (out_data_out),
    .out_level_out (out_level_out)
  );

endmodule

### tb/tb_multi_level_priority_fifo.sv
`timescale 1ns / 1ps

module tb_multi_level_priority_fifo import mlpq_pkg::*;;

  localparam int LEVELS = 3;
  localparam int DEPTH  = 8;

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  localparam int RAND_ITEMS   = 2000;
  localparam int QUIET_TAIL   = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    status_t           status;
    logic [DATA_W-1:0] data;
    logic [LEVEL_W-1:0] level;
  } queue_result_t;

  typedef struct {
    logic               action;
    logic [DATA_W-1:0]  value;
    logic [LEVEL_W-1:0] pri;
    bit                 fixed;
    queue_result_t      res;
  } dir_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_action;
  logic signed [DATA_W-1:0]  in_value;
  logic [LEVEL_W-1:0]        in_priority_req;
  logic                      out_strobe;
  logic [STAT_W-1:0]         out_status;
  logic signed [DATA_W-1:0]  out_data_out;
  logic [LEVEL_W-1:0]        out_level_out;

  // shadow copy of the per-level circular buffers
  logic [DATA_W-1:0] lvl_word [LEVELS][DEPTH];
  int unsigned       lvl_head [LEVELS];
  int unsigned       lvl_tail [LEVELS];
  bit                lvl_empty [LEVELS];

  queue_result_t pending_results [$];
  dir_row_t      dir_tab [$];
  int            err_count;
  int            cycle_count;

  multi_level_priority_fifo #(
    .LEVELS(LEVELS),
    .DEPTH (DEPTH)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_value       (in_value),
    .in_priority_req(in_priority_req),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_data_out   (out_data_out),
    .out_level_out  (out_level_out)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic queue_result_t next_queue_result(logic act, logic [DATA_W-1:0] v,
                                                      logic [LEVEL_W-1:0] p);
    queue_result_t r;
    int unsigned lv;
    r.status = ST_EMPTY;
    r.data   = '0;
    r.level  = '0;
    if (act == ACT_ENQ) begin
      if (p >= LEVELS) begin
        r.status = ST_BADPRI;
      end else if (!lvl_empty[p] && lvl_head[p] == (lvl_tail[p] + 1) % DEPTH) begin
        r.status = ST_FULL;
      end else begin
        if (lvl_empty[p]) begin
          lvl_head[p]  = 0;
          lvl_tail[p]  = 0;
          lvl_empty[p] = 1'b0;
        end else begin
          lvl_tail[p] = (lvl_tail[p] + 1) % DEPTH;
        end
        lvl_word[p][lvl_tail[p]] = v;
        r.status = ST_ENQ;
        r.data   = v;
        r.level  = p;
      end
    end else begin
      // strict priority: lowest-numbered non-empty level wins
      for (lv = 0; lv < LEVELS; lv++) begin
        if (!lvl_empty[lv] && r.status == ST_EMPTY) begin
          r.status = ST_DEQ;
          r.data   = lvl_word[lv][lvl_head[lv]];
          r.level  = lv[LEVEL_W-1:0];
          if (lvl_head[lv] == lvl_tail[lv]) begin
            lvl_empty[lv] = 1'b1;
            lvl_head[lv]  = 0;
            lvl_tail[lv]  = 0;
          end else begin
            lvl_head[lv] = (lvl_head[lv] + 1) % DEPTH;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("[%0t] mismatch on %s: got 0x%08h, want 0x%08h", $time, what, got, want);
    err_count++;
  endtask

  function automatic void add_row(logic act, logic [DATA_W-1:0] v, logic [LEVEL_W-1:0] p,
                                  bit fx, status_t s, logic [DATA_W-1:0] d,
                                  logic [LEVEL_W-1:0] l);
    dir_row_t row;
    row.action     = act;
    row.value      = v;
    row.pri        = p;
    row.fixed      = fx;
    row.res.status = s;
    row.res.data   = d;
    row.res.level  = l;
    dir_tab.push_back(row);
  endfunction

  // present one beat and hold it until accepted
  task automatic send_beat(logic act, logic [DATA_W-1:0] v, logic [LEVEL_W-1:0] p,
                           bit fx, queue_result_t fixed_res);
    queue_result_t r;
    @(negedge clk);
    start           <= 1'b1;
    in_action       <= act;
    in_value        <= v;
    in_priority_req <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = next_queue_result(act, v, p);
    if (fx) pending_results.push_back(fixed_res);
    else pending_results.push_back(r);
  endtask

  task automatic hold_idle(int n);
    @(negedge clk);
    start           <= 1'b0;
    in_action       <= 1'($urandom);
    in_value        <= $urandom;
    in_priority_req <= 3'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(0, 3) == 0) hold_idle($urandom_range(1, 13));
  endtask

  always @(posedge clk) begin
    queue_result_t e;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result status", out_status, '0);
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) report_mismatch("status", out_status, e.status);
        if (out_data_out !== e.data) report_mismatch("data_out", out_data_out, e.data);
        if (out_level_out !== e.level) report_mismatch("level_out", out_level_out, e.level);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** multi_level_priority_fifo: FAILED **");
      $finish;
    end
  end

  initial begin
    queue_result_t none;
    int i;
    int phase_left;
    int enq_pct;
    logic act;
    logic [DATA_W-1:0] v;
    logic [LEVEL_W-1:0] p;

    rst_n           = 1'b0;
    start           = 1'b0;
    in_action       = ACT_ENQ;
    in_value        = '0;
    in_priority_req = '0;
    none.status     = ST_ENQ;
    none.data       = '0;
    none.level      = '0;
    for (i = 0; i < LEVELS; i++) begin
      lvl_head[i]  = 0;
      lvl_tail[i]  = 0;
      lvl_empty[i] = 1'b1;
    end

    // directed rows: fixed expectations where obvious, predictor elsewhere
    add_row(ACT_DEQ, 32'h0000_0000, 3'd0, 1, ST_EMPTY, 32'h0, 3'd0);
    add_row(ACT_ENQ, 32'h1234_5678, 3'd7, 1, ST_BADPRI, 32'h0, 3'd0);
    add_row(ACT_ENQ, 32'hdead_beef, 3'd3, 1, ST_BADPRI, 32'h0, 3'd0);
    add_row(ACT_ENQ, 32'h7fff_ffff, 3'd2, 1, ST_ENQ, 32'h7fff_ffff, 3'd2);
    add_row(ACT_ENQ, 32'h8000_0000, 3'd1, 1, ST_ENQ, 32'h8000_0000, 3'd1);
    add_row(ACT_ENQ, 32'hffff_ffff, 3'd0, 1, ST_ENQ, 32'hffff_ffff, 3'd0);
    add_row(ACT_DEQ, 32'hffff_ffff, 3'd7, 1, ST_DEQ, 32'hffff_ffff, 3'd0);
    add_row(ACT_DEQ, 32'h5555_aaaa, 3'd4, 1, ST_DEQ, 32'h8000_0000, 3'd1);
    add_row(ACT_DEQ, 32'h0000_0000, 3'd0, 1, ST_DEQ, 32'h7fff_ffff, 3'd2);
    add_row(ACT_DEQ, 32'h0000_0000, 3'd0, 1, ST_EMPTY, 32'h0, 3'd0);
    for (i = 0; i < DEPTH; i++)
      add_row(ACT_ENQ, 32'h0000_0000 + i, 3'd0, 0, ST_ENQ, 32'h0, 3'd0);
    add_row(ACT_ENQ, 32'h0bad_0001, 3'd0, 1, ST_FULL, 32'h0, 3'd0);
    add_row(ACT_DEQ, 32'h0000_0000, 3'd0, 0, ST_ENQ, 32'h0, 3'd0);
    add_row(ACT_ENQ, 32'h0000_0000, 3'd0, 0, ST_ENQ, 32'h0, 3'd0);
    add_row(ACT_ENQ, 32'h0bad_0002, 3'd0, 1, ST_FULL, 32'h0, 3'd0);
    add_row(ACT_ENQ, 32'h0000_0000, 3'd1, 0, ST_ENQ, 32'h0, 3'd0);
    add_row(ACT_DEQ, 32'h0000_0000, 3'd0, 0, ST_ENQ, 32'h0, 3'd0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[k]) begin
      maybe_idle();
      send_beat(dir_tab[k].action, dir_tab[k].value, dir_tab[k].pri, dir_tab[k].fixed,
                dir_tab[k].res);
    end

    // alternate fill-heavy and drain-heavy phases so levels hit full and empty often
    phase_left = 0;
    enq_pct    = 50;
    for (i = 0; i < RAND_ITEMS; i++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 80);
        enq_pct    = ($urandom_range(0, 1) == 0) ? 80 : 25;
      end
      phase_left--;
      act = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
      case ($urandom_range(0, 9))
        0:       v = 32'h7fff_ffff;
        1:       v = 32'h8000_0000;
        2:       v = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hffff_ffff;
        default: v = $urandom;
      endcase
      p = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(3, 7))
                                      : 3'($urandom_range(0, LEVELS - 1));
      if (i < RAND_ITEMS - QUIET_TAIL) maybe_idle();
      send_beat(act, v, p, 0, none);
    end

    @(negedge clk);
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("** multi_level_priority_fifo: PASSED **");
    end else begin
      $display("** multi_level_priority_fifo: FAILED **");
    end
    $finish;
  end

endmodule
